// ----- hdl/ddma_pkg.sv -----
// Shared types and constants for the dual DMA controller.
`timescale 1ns / 1ps
package ddma_pkg;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RAISE = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [3:0] R_CMD    = 4'd8;
  localparam logic [3:0] R_REQ    = 4'd9;
  localparam logic [3:0] R_SMASK  = 4'd10;
  localparam logic [3:0] R_MODE   = 4'd11;
  localparam logic [3:0] R_CLRFF  = 4'd12;
  localparam logic [3:0] R_MCLR   = 4'd13;
  localparam logic [3:0] R_CLRMSK = 4'd14;
  localparam logic [3:0] R_MASK   = 4'd15;

  // Channel entry held in the channel memory.
  typedef struct packed {
    logic [15:0] page;
    logic [15:0] base_addr;
    logic [15:0] run_addr;
    logic [15:0] base_cnt;
    logic [15:0] run_cnt;
    logic [7:0]  mode;
  } chan_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        mem_valid;
    logic [31:0] mem_addr;
    logic        mem_to_memory;
    logic [1:0]  mem_size;
    logic [2:0]  mem_channel;
    logic        done_res;
  } result_t;

  // Page port low nibble to channel; bit 3 set means no channel.
  function automatic logic [3:0] page_map(input logic [3:0] idx);
    logic [3:0] r;
    unique case (idx)
      4'd1: r = 4'd2;
      4'd2: r = 4'd3;
      4'd3: r = 4'd1;
      4'd7: r = 4'd0;
      4'd9: r = 4'd6;
      4'd10: r = 4'd7;
      4'd11: r = 4'd5;
      4'd15: r = 4'd4;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ddma_chan_mem.sv -----
// Eight-entry channel memory with registered read.
`timescale 1ns / 1ps
module ddma_chan_mem
  import ddma_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  logic [2:0] waddr,
  input  chan_t      wdata,
  input  logic [2:0] raddr,
  output chan_t      rdata
);

  chan_t mem [8];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dual_dma_controller.sv -----
// Top level of the cascaded pair of DMA controllers.
// The s_axis channel takes one item: a port read, a port write, a request
// raise or a service tick. Each item gives exactly one result on m_axis.
// Each item is processed in order: decode and issue the channel memory read,
// read-modify-write of the channel entry, then the result register.
// A new item is accepted once the previous one has left the output
// register, so the block takes no new item before the last one is out.
// The channel state sits in an 8-entry memory with registered read; the
// memory is not cleared, so after reset the block runs a clearing pass
// (tready low) to zero every entry. Controller registers (command, status,
// mask, flip-flop) are flip-flops reset by rst, the mask to 15. When m_axis_tready
// is low the result holds in the output register and no item is accepted.
`timescale 1ns / 1ps
module dual_dma_controller
  import ddma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: port[10:0], wdata[18:11], dreq_line[21:19], zeros
  input  logic [23:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rdata[7:0], mem_addr[39:8], mem_size[41:40], mem_channel[44:42], zeros
  output logic [47:0] m_axis_tdata,
  // tuser: mem_valid[0], mem_to_memory[1], done_res[2]
  output logic [2:0]  m_axis_tuser
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t      state;
  logic [3:0]  clr_cnt;
  logic [1:0]  kind;
  logic [10:0] port;
  logic [7:0]  wd;
  logic [2:0]  line;
  logic [7:0]  cmd   [2];
  logic [7:0]  stat  [2];
  logic [7:0]  mask  [2];
  logic        ff    [2];
  result_t     res;

  logic        we;
  logic [2:0]  waddr;
  logic [2:0]  raddr;
  logic [3:0]  in_pmap;
  chan_t       wentry;
  chan_t       rentry;

  ddma_chan_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  // Decode of the latched item
  logic       is_ctl;
  logic       ctl;
  logic [3:0] reg_idx;
  logic       is_plo;
  logic       is_phi;
  logic [3:0] pmap;
  logic [2:0] reg_ch;
  logic [2:0] pend_ch;
  logic       pend_any;

  always_comb begin
    is_ctl  = 1'b0;
    ctl     = 1'b0;
    reg_idx = port[3:0];
    if (port < 11'h010) begin
      is_ctl = 1'b1;
    end else if (port >= 11'h0C0 && port <= 11'h0DF && !port[0]) begin
      is_ctl  = 1'b1;
      ctl     = 1'b1;
      reg_idx = port[4:1];
    end
    is_plo = port >= 11'h080 && port <= 11'h08F;
    is_phi = port >= 11'h480 && port <= 11'h48F;
    pmap   = page_map(port[3:0]);
    reg_ch = {ctl, reg_idx[2:1]};
  end

  always_comb begin
    pend_any = 1'b0;
    pend_ch  = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (stat[i / 4][4 + (i % 4)] && !mask[i / 4][i % 4]) begin
        pend_any = 1'b1;
        pend_ch  = 3'(i);
      end
    end
  end

  assign in_pmap = page_map(s_axis_tdata[3:0]);

  always_comb begin
    if (state == ST_CLEAR) begin
      raddr = 3'd0;
    end else if (s_axis_tuser == REQ_TICK) begin
      raddr = pend_ch;
    end else if (s_axis_tdata[10:0] < 11'h010) begin
      if (s_axis_tuser == REQ_WRITE && s_axis_tdata[3:0] == R_MODE) begin
        raddr = {1'b0, s_axis_tdata[12:11]};
      end else begin
        raddr = {1'b0, s_axis_tdata[2:1]};
      end
    end else if (s_axis_tdata[10:4] == 7'h08 || s_axis_tdata[10:4] == 7'h48) begin
      raddr = in_pmap[2:0];
    end else if (s_axis_tuser == REQ_WRITE && s_axis_tdata[4:1] == R_MODE) begin
      raddr = {1'b1, s_axis_tdata[12:11]};
    end else begin
      raddr = {1'b1, s_axis_tdata[3:2]};
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {3'b0, res.mem_channel, res.mem_size, res.mem_addr, res.rdata};
  assign m_axis_tuser  = {res.done_res, res.mem_to_memory, res.mem_valid};

  // Execute stage: combinational read-modify-write of the fetched entry
  result_t    r_n;
  chan_t      e_n;
  logic       we_n;
  logic [2:0] wa_n;
  logic [7:0] stat_n [2];
  logic [7:0] mask_n [2];
  logic [7:0] cmd_n  [2];
  logic       ff_n   [2];
  logic [2:0] tch;
  logic       wide;
  logic       last;
  logic [16:0] sh;
  logic [15:0] v;

  always_comb begin
    r_n    = '0;
    e_n    = rentry;
    we_n   = 1'b0;
    wa_n   = raddr;
    stat_n = stat;
    mask_n = mask;
    cmd_n  = cmd;
    ff_n   = ff;
    tch    = pend_ch;
    wide   = pend_ch[2];
    last   = rentry.run_cnt == 16'd0;
    sh     = {rentry.run_addr, 1'b0};
    v      = reg_idx[0] ? rentry.run_cnt : rentry.run_addr;
    case (kind)
      REQ_READ: begin
        r_n.rdata = 8'hFF;
        if (is_ctl) begin
          if (!reg_idx[3]) begin
            r_n.rdata = ff[ctl] ? v[15:8] : v[7:0];
            ff_n[ctl] = !ff[ctl];
          end else if (reg_idx == R_CMD) begin
            r_n.rdata = stat[ctl];
          end else if (reg_idx == R_MASK) begin
            r_n.rdata = mask[ctl];
          end
        end else if ((is_plo || is_phi) && !pmap[3]) begin
          r_n.rdata = is_plo ? rentry.page[7:0] : rentry.page[15:8];
        end
      end
      REQ_WRITE: begin
        if (is_ctl) begin
          if (!reg_idx[3]) begin
            we_n = 1'b1;
            wa_n = reg_ch;
            if (reg_idx[0]) begin
              if (ff[ctl]) begin
                e_n.base_cnt[15:8] = wd;
                e_n.run_cnt[15:8]  = wd;
              end else begin
                e_n.base_cnt[7:0] = wd;
                e_n.run_cnt[7:0]  = wd;
              end
            end else begin
              if (ff[ctl]) begin
                e_n.base_addr[15:8] = wd;
                e_n.run_addr[15:8]  = wd;
              end else begin
                e_n.base_addr[7:0] = wd;
                e_n.run_addr[7:0]  = wd;
              end
            end
            ff_n[ctl] = !ff[ctl];
          end else begin
            unique case (reg_idx)
              R_CMD: cmd_n[ctl] = wd;
              R_REQ: begin
                stat_n[ctl][wd[1:0]]       = 1'b0;
                stat_n[ctl][4 + wd[1:0]]   = wd[2];
              end
              R_SMASK: mask_n[ctl][wd[1:0]] = wd[2];
              R_MODE: begin
                we_n = 1'b1;
                wa_n = {ctl, wd[1:0]};
              end
              R_CLRFF: ff_n[ctl] = 1'b0;
              R_MCLR: begin
                ff_n[ctl]   = 1'b0;
                cmd_n[ctl]  = 8'd0;
                stat_n[ctl] = 8'd0;
                mask_n[ctl] = 8'd15;
              end
              R_CLRMSK: mask_n[ctl] = 8'd0;
              default: mask_n[ctl] = wd;
            endcase
          end
        end else if ((is_plo || is_phi) && !pmap[3]) begin
          we_n = 1'b1;
          wa_n = pmap[2:0];
          if (is_plo) begin
            e_n.page[7:0] = wd;
          end else begin
            e_n.page[15:8] = wd;
          end
        end
      end
      REQ_RAISE: begin
        stat_n[line[2]][4 + line[1:0]] = 1'b1;
      end
      default: begin
        if (pend_any) begin
          r_n.mem_valid     = 1'b1;
          r_n.mem_addr      = {rentry.page, wide ? sh[15:0] : rentry.run_addr};
          r_n.mem_to_memory = rentry.mode[3:2] == 2'b01;
          r_n.mem_size      = wide ? 2'd2 : 2'd1;
          r_n.mem_channel   = tch;
          we_n = 1'b1;
          wa_n = tch;
          e_n.run_addr = rentry.mode[5] ? rentry.run_addr - 16'd1 : rentry.run_addr + 16'd1;
          e_n.run_cnt  = rentry.run_cnt - 16'd1;
          if (last) begin
            if (rentry.mode[4]) begin
              e_n.run_addr = rentry.base_addr;
              e_n.run_cnt  = rentry.base_cnt;
            end
            stat_n[tch[2]][4 + tch[1:0]] = 1'b0;
            stat_n[tch[2]][tch[1:0]]     = 1'b1;
            r_n.done_res = 1'b1;
          end
        end
      end
    endcase
  end

  logic [2:0] tick_ch;

  // Mode writes use the whole byte; keep it separate from the entry fetch.
  always_comb begin
    we     = 1'b0;
    waddr  = wa_n;
    wentry = e_n;
    if (state == ST_CLEAR) begin
      we     = 1'b1;
      waddr  = clr_cnt[2:0];
      wentry = '0;
    end else if (state == ST_EXEC) begin
      we = we_n;
      if (kind == REQ_WRITE && is_ctl && reg_idx == R_MODE) begin
        wentry      = e_n;
        wentry.mode = wd;
      end
    end
  end

  assign tick_ch = pend_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= 4'd0;
      for (int i = 0; i < 2; i++) begin
        cmd[i]  <= 8'd0;
        stat[i] <= 8'd0;
        mask[i] <= 8'd15;
        ff[i]   <= 1'b0;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 4'd1;
          if (clr_cnt == 4'd7) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          stat  <= stat_n;
          mask  <= mask_n;
          cmd   <= cmd_n;
          ff    <= ff_n;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      kind <= s_axis_tuser;
      port <= s_axis_tdata[10:0];
      wd   <= s_axis_tdata[18:11];
      line <= s_axis_tdata[21:19];
    end
    if (state == ST_EXEC) begin
      res <= r_n;
    end
  end

  // The fetched tick channel is still the pending one at execute time.
  ap_tick_ch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && kind == REQ_TICK && pend_any) |-> tick_ch == $past(raddr))
    else $error("tick channel changed between fetch and execute");

  ap_one_valid: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output both open");

  ap_done_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[0])
    else $error("done without element");

  ap_clear_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

endmodule

// ----- bench/dual_dma_controller_tb.sv -----
// Self-checking testbench for the cascaded pair of DMA controllers.
`timescale 1ns / 1ps
module dual_dma_controller_tb;
  import ddma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1700;

  class dma_scoreboard;
    logic [15:0] page[8];
    logic [15:0] base_addr[8];
    logic [15:0] run_addr[8];
    logic [15:0] base_cnt[8];
    logic [15:0] run_cnt[8];
    logic [7:0]  mode[8];
    logic [7:0]  cmd[2];
    logic [7:0]  status[2];
    logic [7:0]  mask[2];
    logic        flop[2];
    logic [3:0]  page_chan[16];
    result_t     expected_q[$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < 8; i++) begin
        page[i] = '0; base_addr[i] = '0; run_addr[i] = '0;
        base_cnt[i] = '0; run_cnt[i] = '0; mode[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
        cmd[i] = '0; status[i] = '0; mask[i] = 8'd15; flop[i] = 1'b0;
      end
      page_chan = '{4'd8, 4'd2, 4'd3, 4'd1, 4'd8, 4'd8, 4'd8, 4'd0,
                    4'd8, 4'd6, 4'd7, 4'd5, 4'd8, 4'd8, 4'd8, 4'd4};
      errors = 0;
    endfunction

    function bit decode(input logic [10:0] port, output int ctl, output logic [3:0] r);
      ctl = 0;
      r = '0;
      if (port < 11'h10) begin
        r = port[3:0];
        return 1'b1;
      end
      if (port >= 11'h0C0 && port <= 11'h0DF && !port[0]) begin
        ctl = 1;
        r = port[4:1];
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [7:0] read_port(input logic [10:0] port);
      int ctl;
      logic [3:0] r;
      int ch;
      logic [15:0] v;
      logic [7:0] b;
      if (decode(port, ctl, r)) begin
        if (r < 8) begin
          ch = ctl * 4 + r[2:1];
          v = r[0] ? run_cnt[ch] : run_addr[ch];
          b = flop[ctl] ? v[15:8] : v[7:0];
          flop[ctl] = ~flop[ctl];
          return b;
        end
        if (r == R_CMD) return status[ctl];
        if (r == R_MASK) return mask[ctl];
        return 8'hFF;
      end
      if (port >= 11'h080 && port <= 11'h08F)
        return page_chan[port[3:0]] < 8 ? page[page_chan[port[3:0]]][7:0] : 8'hFF;
      if (port >= 11'h480 && port <= 11'h48F)
        return page_chan[port[3:0]] < 8 ? page[page_chan[port[3:0]]][15:8] : 8'hFF;
      return 8'hFF;
    endfunction

    function void write_port(input logic [10:0] port, input logic [7:0] d);
      int ctl;
      logic [3:0] r;
      int ch;
      int sel;
      sel = d[1:0];
      if (decode(port, ctl, r)) begin
        if (r < 8) begin
          ch = ctl * 4 + r[2:1];
          if (r[0]) begin
            if (flop[ctl]) begin
              base_cnt[ch][15:8] = d; run_cnt[ch][15:8] = d;
            end else begin
              base_cnt[ch][7:0] = d; run_cnt[ch][7:0] = d;
            end
          end else begin
            if (flop[ctl]) begin
              base_addr[ch][15:8] = d; run_addr[ch][15:8] = d;
            end else begin
              base_addr[ch][7:0] = d; run_addr[ch][7:0] = d;
            end
          end
          flop[ctl] = ~flop[ctl];
          return;
        end
        case (r)
          R_CMD: cmd[ctl] = d;
          R_REQ: begin
            status[ctl][sel] = 1'b0;
            status[ctl][4 + sel] = d[2];
          end
          R_SMASK: mask[ctl][sel] = d[2];
          R_MODE: mode[ctl * 4 + sel] = d;
          R_CLRFF: flop[ctl] = 1'b0;
          R_MCLR: begin
            flop[ctl] = 1'b0; cmd[ctl] = '0; status[ctl] = '0; mask[ctl] = 8'd15;
          end
          R_CLRMSK: mask[ctl] = '0;
          default: mask[ctl] = d;
        endcase
        return;
      end
      if (port >= 11'h080 && port <= 11'h08F && page_chan[port[3:0]] < 8)
        page[page_chan[port[3:0]]][7:0] = d;
      else if (port >= 11'h480 && port <= 11'h48F && page_chan[port[3:0]] < 8)
        page[page_chan[port[3:0]]][15:8] = d;
    endfunction

    function result_t service_tick();
      result_t res;
      int ch;
      int ctl;
      int bt;
      logic [15:0] a;
      logic [15:0] shifted;
      res = '0;
      ch = 8;
      for (int c = 0; c < 8; c++) begin
        if (status[c / 4][4 + c % 4] && !mask[c / 4][c % 4]) begin
          ch = c;
          break;
        end
      end
      if (ch == 8) return res;
      ctl = ch / 4;
      bt = ch % 4;
      a = run_addr[ch];
      shifted = ch >= 4 ? {a[14:0], 1'b0} : a;
      res.mem_valid = 1'b1;
      res.mem_addr = {page[ch], shifted};
      res.mem_to_memory = mode[ch][3:2] == 2'b01;
      res.mem_size = ch >= 4 ? 2'd2 : 2'd1;
      res.mem_channel = ch[2:0];
      run_addr[ch] = mode[ch][5] ? a - 16'd1 : a + 16'd1;
      if (run_cnt[ch] == 16'd0) begin
        run_cnt[ch] = 16'hFFFF;
        if (mode[ch][4]) begin
          run_addr[ch] = base_addr[ch];
          run_cnt[ch] = base_cnt[ch];
        end
        status[ctl][4 + bt] = 1'b0;
        status[ctl][bt] = 1'b1;
        res.done_res = 1'b1;
      end else begin
        run_cnt[ch] = run_cnt[ch] - 16'd1;
      end
      return res;
    endfunction

    function void note_item(input logic [1:0] kind, input logic [10:0] port,
                            input logic [7:0] wd, input logic [2:0] line);
      result_t res;
      res = '0;
      case (kind)
        REQ_READ: res.rdata = read_port(port);
        REQ_WRITE: write_port(port, wd);
        REQ_RAISE: status[line[2]][4 + line[1:0]] = 1'b1;
        default: res = service_tick();
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(input logic [47:0] data, input logic [2:0] flags);
      result_t got;
      result_t exp;
      got.rdata = data[7:0];
      got.mem_addr = data[39:8];
      got.mem_size = data[41:40];
      got.mem_channel = data[44:42];
      got.mem_valid = flags[0];
      got.mem_to_memory = flags[1];
      got.done_res = flags[2];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = expected_q.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: exp rdata=%h v=%b addr=%h tm=%b sz=%0d ch=%0d done=%b",
                   exp.rdata, exp.mem_valid, exp.mem_addr, exp.mem_to_memory,
                   exp.mem_size, exp.mem_channel, exp.done_res,
                   "\n                 got rdata=%h v=%b addr=%h tm=%b sz=%0d ch=%0d done=%b",
                   got.rdata, got.mem_valid, got.mem_addr, got.mem_to_memory,
                   got.mem_size, got.mem_channel, got.done_res);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  dma_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          drain_hold = 1'b0;

  always #10 clk = ~clk;

  dual_dma_controller u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dual_dma_controller: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_item(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[18:11],
                   s_axis_tdata[21:19]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Output backpressure: random ready runs mixed with short or long stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (drain_hold || $urandom_range(0, 1)) begin
      m_axis_tready <= 1'b1;
      stall_left <= $urandom_range(0, 20);
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  task automatic send(input logic [1:0] kind, input logic [10:0] port,
                      input logic [7:0] wd = 8'h00, input logic [2:0] line = 3'd0);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {2'b00, line, wd, port};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [10:0] reg_port(input int ctl, input logic [3:0] r);
    return ctl == 0 ? {7'd0, r} : 11'h0C0 + {6'd0, r, 1'b0};
  endfunction

  function automatic logic [3:0] page_index(input int ch);
    logic [3:0] idx [8];
    idx = '{4'd7, 4'd3, 4'd1, 4'd2, 4'd15, 4'd11, 4'd9, 4'd10};
    return idx[ch];
  endfunction

  // Set up one channel, enable it and send it cnt_lo plus one to three service ticks.
  task automatic run_transfer();
    int ch;
    int ctl;
    logic [3:0] r;
    logic [7:0] cnt_lo;
    int unsigned ticks;
    ch = $urandom_range(0, 7);
    ctl = ch / 4;
    r = 4'(ch % 4) << 1;
    cnt_lo = 8'($urandom_range(0, 5));
    send(REQ_WRITE, reg_port(ctl, R_CLRFF), 8'($urandom));
    send(REQ_WRITE, reg_port(ctl, r), 8'($urandom));
    send(REQ_WRITE, reg_port(ctl, r), 8'($urandom));
    send(REQ_WRITE, reg_port(ctl, r + 4'd1), cnt_lo);
    send(REQ_WRITE, reg_port(ctl, r + 4'd1), $urandom_range(0, 15) == 0 ? 8'($urandom) : 8'd0);
    send(REQ_WRITE, reg_port(ctl, R_MODE), {6'($urandom), 2'(ch % 4)});
    send(REQ_WRITE, {7'h08, page_index(ch)}, 8'($urandom));
    send(REQ_WRITE, {7'h48, page_index(ch)}, 8'($urandom));
    send(REQ_WRITE, reg_port(ctl, R_SMASK), {5'($urandom), 1'b0, 2'(ch % 4)});
    if ($urandom_range(0, 1))
      send(REQ_RAISE, 11'($urandom), 8'($urandom), 3'(ch));
    else
      send(REQ_WRITE, reg_port(ctl, R_REQ), {5'($urandom), 1'b1, 2'(ch % 4)});
    ticks = cnt_lo + $urandom_range(1, 3);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 5) == 0)
        send(REQ_READ, reg_port(ctl, $urandom_range(0, 1) ? R_CMD : r), 8'($urandom));
      send(REQ_TICK, 11'($urandom), 8'($urandom), 3'($urandom));
    end
  endtask

  task automatic send_noise();
    logic [10:0] port;
    int unsigned r;
    r = $urandom_range(0, 4);
    if (r == 0) port = 11'($urandom_range(0, 1167));
    else if (r == 1) port = 11'($urandom_range(0, 15));
    else if (r == 2) port = 11'($urandom_range(11'h0C0, 11'h0DF));
    else if (r == 3) port = 11'($urandom_range(11'h080, 11'h08F));
    else port = 11'($urandom_range(11'h480, 11'h48F));
    send(2'($urandom), port, 8'($urandom), 3'($urandom));
  endtask

  initial begin
    int unsigned sent;
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(REQ_TICK, 11'h000);
    send(REQ_READ, 11'h008);
    send(REQ_READ, 11'h00F);
    send(REQ_READ, 11'h0DE);
    send(REQ_READ, 11'h009);
    send(REQ_READ, 11'h0C1);
    send(REQ_READ, 11'h080);
    send(REQ_WRITE, 11'h087, 8'hFF);
    send(REQ_WRITE, 11'h487, 8'hFF);
    send(REQ_READ, 11'h087);
    send(REQ_READ, 11'h487);
    send(REQ_WRITE, 11'h0C0, 8'hFF);
    send(REQ_WRITE, 11'h0C0, 8'hFF);
    send(REQ_READ, 11'h0C0);
    send(REQ_READ, 11'h0C0);
    send(REQ_WRITE, 11'h00E, 8'h00);
    send(REQ_WRITE, 11'h0DC, 8'h00);
    send(REQ_WRITE, 11'h0D6, 8'hFF);
    send(REQ_RAISE, 11'h000, 8'h00, 3'd7);
    send(REQ_RAISE, 11'h000, 8'h00, 3'd0);
    send(REQ_TICK, 11'h7FF, 8'hFF, 3'd7);
    send(REQ_TICK, 11'h000);
    send(REQ_READ, 11'h0D0);
    send(REQ_WRITE, 11'h00D, 8'h00);
    send(REQ_WRITE, 11'h0DA, 8'h00);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        run_transfer();
        sent += 14;
      end else begin
        send_noise();
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    drain_hold = 1'b1;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("dual_dma_controller: match");
    else
      $display("dual_dma_controller: mismatch");
    $finish;
  end

endmodule
